/* rtl/barometric_pressure_compensation_defines.svh */
// assertion macros for the barometric compensation block
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define BPC_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// next-cycle implication
`define BPC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

/* rtl/bpc_pkg.sv */
// shared types and constants for the barometric compensation block
`default_nettype none
package bpc_pkg;
    localparam logic [2:0] REG_AC_S = 3'd0;
    localparam logic [2:0] REG_AC_U = 3'd1;
    localparam logic [2:0] REG_B    = 3'd2;
    localparam logic [2:0] REG_M    = 3'd3;
    localparam logic [2:0] REG_OSS  = 3'd4;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    localparam logic [31:0] K_B6_OFS  = 32'd4000;
    localparam logic [31:0] K_SCALE   = 32'd50000;
    localparam logic [31:0] K_C3038   = 32'd3038;
    localparam logic [31:0] K_CM7357  = 32'hFFFF_E343;
    localparam logic [31:0] K_C3791   = 32'd3791;
    localparam logic [31:0] K_SIGN    = 32'h8000_0000;

    typedef enum logic [4:0] {
        S_IDLE, S_T0, S_T1, S_TDIV, S_TWAIT, S_TEND,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
        S_PDIV, S_PWAIT, S_P9, S_P10, S_P11, S_P12, S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

/* rtl/bpc_divider.sv */
// unsigned 32-bit restoring divider, one quotient bit per cycle
`default_nettype none
module bpc_divider
    import bpc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic [31:0] r_rem, n_rem, r_quo, n_quo, r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [32:0] w_trial;

    always_comb begin
        n_rem = r_rem; n_quo = r_quo; n_den = r_den;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        w_trial = {r_rem, r_quo[31]} - {1'b0, r_den};
        if (i_req.start) begin
            n_rem = '0; n_quo = i_req.num; n_den = i_req.den;
            n_cnt = 6'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_quo[31]};
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_rem <= n_rem; r_quo <= n_quo; r_den <= n_den;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
`default_nettype wire

/* rtl/barometric_pressure_compensation.sv */
// top level: sequencer around one shared multiplier and a serial divider
//  channel | signals                              | direction
//  request | i_valid o_stall(out) op raw        | in
//  result  | o_valid i_stall(in) kind value status | out
//  config  | i_cfg_we i_cfg_index i_cfg_data      | in
// temperature and pressure results both wait mostly on the serial divide
// next request taken the cycle after the result is taken; a zero divisor skips the divide
// one multiply a cycle through the shared 32x32 multiplier, result registered
// o_stall is high while the sequencer is not idle: after acceptance until the result is taken
// a stalled result holds in the output register; reset clears state, B5 and the config registers
`default_nettype none
module barometric_pressure_compensation
    import bpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_operation,
    input  wire logic [23:0] i_raw_reading,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_kind,
    output logic signed [31:0] o_value,
    output logic             o_status,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data
);
`include "barometric_pressure_compensation_defines.svh"
    logic [47:0] r_acs, r_acu;
    logic [31:0] r_bw, r_mw;
    logic [1:0]  r_oss;
    logic [31:0] r_b5, n_b5;
    t_state      r_st, n_st;
    logic        r_kind, n_kind, r_stat, n_stat, r_neg, n_neg;
    logic [31:0] r_a, n_a, r_b, n_b, r_c, n_c, r_d, n_d, r_e, n_e, r_val, n_val;
    logic [23:0] r_raw, n_raw;
    logic [31:0] w_ma, w_mb, r_prod;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, w_up;
    t_div_req    w_dreq;
    t_div_rsp    w_drsp;

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
        asr = 32'($signed(v) >>> n);
    endfunction
    function automatic logic [31:0] sx(input logic [15:0] v);
        sx = {{16{v[15]}}, v};
    endfunction

    assign ac1 = sx(r_acs[47:32]); assign ac2 = sx(r_acs[31:16]); assign ac3 = sx(r_acs[15:0]);
    assign ac4 = {16'd0, r_acu[47:32]}; assign ac5 = {16'd0, r_acu[31:16]};
    assign ac6 = {16'd0, r_acu[15:0]};
    assign b1 = sx(r_bw[31:16]); assign b2 = sx(r_bw[15:0]);
    assign mc = sx(r_mw[31:16]); assign md = sx(r_mw[15:0]);
    assign w_up = {8'd0, r_raw} >> (4'd8 - {2'd0, r_oss});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acs <= '0; r_acu <= '0; r_bw <= '0; r_mw <= '0; r_oss <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_AC_S: r_acs <= i_cfg_data;
                REG_AC_U: r_acu <= i_cfg_data;
                REG_B:    r_bw  <= i_cfg_data[31:0];
                REG_M:    r_mw  <= i_cfg_data[31:0];
                REG_OSS:  r_oss <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier, operands picked by state
    always_comb begin
        w_ma = '0; w_mb = '0;
        case (r_st)
            S_T0:  begin w_ma = {16'd0, r_raw[15:0]} - ac6; w_mb = ac5; end
            S_P0:  begin w_ma = r_a; w_mb = r_a; end
            S_P1:  begin w_ma = ac2; w_mb = r_a; end
            S_P2:  begin w_ma = b2;  w_mb = r_b; end
            S_P3:  begin w_ma = ac3; w_mb = r_a; end
            S_P4:  begin w_ma = b1;  w_mb = r_b; end
            S_P5:  begin w_ma = w_up - r_c; w_mb = K_SCALE >> r_oss; end
            S_P6:  begin w_ma = ac4; w_mb = r_d; end
            S_P9:  begin w_ma = asr(r_val, 5'd8); w_mb = asr(r_val, 5'd8); end
            S_P10: begin w_ma = r_prod; w_mb = K_C3038; end
            S_P11: begin w_ma = K_CM7357; w_mb = r_val; end
            default: ;
        endcase
    end
    always_ff @(posedge i_clk) r_prod <= w_ma * w_mb;

    // sequencer state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (i_valid) n_st = (i_operation == OP_TEMP) ? S_T0 : S_P0;
            S_T0:    n_st = S_T1;
            S_T1:    n_st = S_TDIV;
            S_TDIV:  n_st = (r_b == '0) ? S_OUT : S_TWAIT;
            S_TWAIT: if (w_drsp.done) n_st = S_TEND;
            S_TEND:  n_st = S_OUT;
            S_P0:    n_st = S_P1;
            S_P1:    n_st = S_P2;
            S_P2:    n_st = S_P3;
            S_P3:    n_st = S_P4;
            S_P4:    n_st = S_P5;
            S_P5:    n_st = S_P6;
            S_P6:    n_st = S_P7;
            S_P7:    n_st = S_P8;
            S_P8:    n_st = (r_d == '0) ? S_OUT : S_PDIV;
            S_PDIV:  n_st = S_PWAIT;
            S_PWAIT: if (w_drsp.done) n_st = S_P9;
            S_P9:    n_st = S_P10;
            S_P10:   n_st = S_P11;
            S_P11:   n_st = S_P12;
            S_P12:   n_st = S_OUT;
            S_OUT:   if (!i_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e; n_val = r_val;
        n_b5 = r_b5; n_kind = r_kind; n_stat = r_stat; n_neg = r_neg; n_raw = r_raw;
        w_dreq = '0;
        case (r_st)
            S_IDLE: if (i_valid) begin
                n_kind = i_operation; n_raw = i_raw_reading; n_stat = 1'b0;
                n_val = '0; n_a = r_b5 - K_B6_OFS;
            end
            S_T1: begin
                n_a = asr(r_prod, 5'd15);
                n_b = asr(r_prod, 5'd15) + md;
            end
            S_TDIV: if (r_b == '0) begin
                n_stat = 1'b1;
            end else begin
                n_neg = mc[31] ^ r_b[31];
                w_dreq.start = 1'b1;
                w_dreq.num = mc[31] ? (32'd0 - (mc << 11)) : (mc << 11);
                w_dreq.den = r_b[31] ? (32'd0 - r_b) : r_b;
            end
            S_TEND: begin
                n_b5 = r_a + (r_neg ? (32'd0 - w_drsp.quo) : w_drsp.quo);
                n_val = asr(n_b5 + 32'd8, 5'd4);
            end
            S_P1: n_b = asr(r_prod, 5'd12);             // sq
            S_P2: n_c = asr(r_prod, 5'd11);             // x2 of b3
            S_P3: n_c = r_c + asr(r_prod, 5'd11);       // x3
            S_P4: begin
                n_e = asr(r_prod, 5'd13);
                n_c = asr((((ac1 << 2) + r_c) << r_oss) + 32'd2, 5'd2);
            end
            S_P5: n_d = asr(r_e + asr(r_prod, 5'd16) + 32'd2, 5'd2) + 32'd32768;
            S_P6: n_e = r_prod;                         // b7
            S_P7: n_d = r_prod >> 15;                   // b4
            S_P8: if (r_d == '0) n_stat = 1'b1;
            S_PDIV: begin
                w_dreq.start = 1'b1;
                w_dreq.num = r_e[31] ? r_e : (r_e << 1);
                w_dreq.den = r_d;
            end
            S_PWAIT: if (w_drsp.done)
                n_val = r_e[31] ? (w_drsp.quo << 1) : w_drsp.quo;
            S_P10: n_a = asr(r_prod, 5'd16);
            S_P11: n_a = asr(r_prod, 5'd16);            // x1, from the product read in P11
            S_P12: n_val = r_val + asr(r_a + asr(r_prod, 5'd16) + K_C3791, 5'd4);
            default: ;
        endcase
    end

    bpc_divider u_div (.i_clk, .i_rst_n, .i_req(w_dreq), .o_rsp(w_drsp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_b5 <= '0;
        end else begin
            r_st <= n_st; r_b5 <= n_b5;
        end
        r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d; r_e <= n_e; r_val <= n_val;
        r_kind <= n_kind; r_stat <= n_stat; r_neg <= n_neg; r_raw <= n_raw;
    end

    assign o_stall  = (r_st != S_IDLE);
    assign o_valid  = (r_st == S_OUT);
    assign o_kind   = r_kind;
    assign o_value  = r_stat ? 32'sd0 : $signed(r_val);
    assign o_status = r_stat;

    `BPC_ASSERT_IMP(a_div_idle, i_clk, i_rst_n, r_st == S_IDLE, !w_drsp.busy)
    `BPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_value))
    `BPC_ASSERT_IMP(a_stall_busy, i_clk, i_rst_n, o_valid, o_stall)
endmodule
`default_nettype wire
